@@ hdl/ocu_pkg.sv @@
// ----------------------------------------------------------------------------
// ocu_pkg: shared types and constants of the orbit camera update unit
// Register codes, controller states, datapath operations and the elaboration
// time sine function that fills the quarter-wave table.
// ----------------------------------------------------------------------------
`default_nettype none

package ocu_pkg;

	// Default number of trig table index bits (entries per full turn = 2**bits).
	localparam int TRIG_TABLE_BITS_DEF = 10;

	// Configuration port geometry.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_CENTER_Z = 2'd2;

	// Angle and length constants (angles in 1/256 degree, lengths Q16.16).
	localparam int TURN_UNITS  = 92160;
	localparam int PITCH_LIMIT = 22784;
	localparam int DIST_MIN    = 65536;

	// Q30 constants of the sine series.
	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint Q30_HALF_PI = 64'sd1686629713;

	// Orbit center, one signed Q15.16 value per axis.
	typedef struct packed {
		logic signed [30:0] x;
		logic signed [30:0] y;
		logic signed [30:0] z;
	} center_t;

	// Controller states, one per step of the frame update.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ANGLES,
		ST_DIV_YAW,
		ST_WRAP_YAW,
		ST_DIV_PIDX,
		ST_GET_PIDX,
		ST_DIV_YIDX,
		ST_GET_YIDX,
		ST_RD_SP,
		ST_RD_CP,
		ST_RD_SY,
		ST_RD_CY,
		ST_MUL_H,
		ST_MUL_V,
		ST_MUL_X,
		ST_MUL_Z,
		ST_TGT_Z,
		ST_DIFF,
		ST_SDIV_X,
		ST_SUM_X,
		ST_SDIV_Y,
		ST_SUM_Y,
		ST_SDIV_Z,
		ST_SUM_Z,
		ST_FINISH
	} state_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_ANGLES,
		OP_DIV_YAW,
		OP_WRAP_YAW,
		OP_DIV_PIDX,
		OP_GET_PIDX,
		OP_DIV_YIDX,
		OP_GET_YIDX,
		OP_RD_SP,
		OP_RD_CP,
		OP_RD_SY,
		OP_RD_CY,
		OP_MUL_H,
		OP_MUL_V,
		OP_MUL_X,
		OP_MUL_Z,
		OP_TGT_Z,
		OP_DIFF,
		OP_SDIV_X,
		OP_SUM_X,
		OP_SDIV_Y,
		OP_SUM_Y,
		OP_SDIV_Z,
		OP_SUM_Z
	} op_t;

	// Command bundle from the controller to the datapath.
	typedef struct packed {
		op_t  op;
		logic load;
		logic emit;
	} cmd_t;

	// Sine of k steps of a quarter wave split into 2**(bits-2) steps, Q1.15.
	// Only evaluated with constant arguments to build the table.
	function automatic logic [14:0] ocu_quarter_sine(input int unsigned k,
			input int unsigned bits);
		longint x;
		longint x2;
		longint t;
		longint s;
		longint r;
		x  = (longint'(k) * Q30_HALF_PI) >>> (bits - 2);
		x2 = (x * x) >>> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 110;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
		s  = (x * t) >>> 30;
		r  = (s + 64'sd16384) >>> 15;
		if (r > 64'sd32767) begin
			r = 64'sd32767;
		end
		if (r < 64'sd0) begin
			r = 64'sd0;
		end
		return 15'(r);
	endfunction

endpackage

`default_nettype wire

@@ hdl/ocu_regs.sv @@
// ----------------------------------------------------------------------------
// ocu_regs: configuration registers of the orbit camera update unit
// APB-style port holding the three orbit center coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module ocu_regs import ocu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output center_t                center
);

	logic       wr_en;
	logic [1:0] reg_idx;
	center_t    center_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign center  = center_q;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CENTER_X: center_q.x <= pwdata[30:0];
				REG_CENTER_Y: center_q.y <= pwdata[30:0];
				REG_CENTER_Z: center_q.z <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// Read back, sign extended to the bus width.
	always_comb begin
		unique case (reg_idx)
			REG_CENTER_X: prdata = {center_q.x[30], center_q.x};
			REG_CENTER_Y: prdata = {center_q.y[30], center_q.y};
			REG_CENTER_Z: prdata = {center_q.z[30], center_q.z};
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/ocu_ctrl.sv @@
// ----------------------------------------------------------------------------
// ocu_ctrl: sequencing controller of the orbit camera update unit
// Accepts one frame tick, steps the datapath through the update, and owns
// the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ocu_ctrl import ocu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   emit_ok;

	// The result register can be loaded when empty or being drained.
	assign emit_ok  = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	// State and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state: a fixed walk through the update steps.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_ANGLES;
			ST_ANGLES:   state_d = ST_DIV_YAW;
			ST_DIV_YAW:  state_d = ST_WRAP_YAW;
			ST_WRAP_YAW: state_d = ST_DIV_PIDX;
			ST_DIV_PIDX: state_d = ST_GET_PIDX;
			ST_GET_PIDX: state_d = ST_DIV_YIDX;
			ST_DIV_YIDX: state_d = ST_GET_YIDX;
			ST_GET_YIDX: state_d = ST_RD_SP;
			ST_RD_SP:    state_d = ST_RD_CP;
			ST_RD_CP:    state_d = ST_RD_SY;
			ST_RD_SY:    state_d = ST_RD_CY;
			ST_RD_CY:    state_d = ST_MUL_H;
			ST_MUL_H:    state_d = ST_MUL_V;
			ST_MUL_V:    state_d = ST_MUL_X;
			ST_MUL_X:    state_d = ST_MUL_Z;
			ST_MUL_Z:    state_d = ST_TGT_Z;
			ST_TGT_Z:    state_d = ST_DIFF;
			ST_DIFF:     state_d = ST_SDIV_X;
			ST_SDIV_X:   state_d = ST_SUM_X;
			ST_SUM_X:    state_d = ST_SDIV_Y;
			ST_SDIV_Y:   state_d = ST_SUM_Y;
			ST_SUM_Y:    state_d = ST_SDIV_Z;
			ST_SDIV_Z:   state_d = ST_SUM_Z;
			ST_SUM_Z:    state_d = ST_FINISH;
			ST_FINISH:   if (emit_ok) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake and the datapath command of each state.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		cmd.load = s_tvalid && (state_q == ST_IDLE);
		cmd.emit = (state_q == ST_FINISH) && emit_ok;
		unique case (state_q)
			ST_ANGLES:   cmd.op = OP_ANGLES;
			ST_DIV_YAW:  cmd.op = OP_DIV_YAW;
			ST_WRAP_YAW: cmd.op = OP_WRAP_YAW;
			ST_DIV_PIDX: cmd.op = OP_DIV_PIDX;
			ST_GET_PIDX: cmd.op = OP_GET_PIDX;
			ST_DIV_YIDX: cmd.op = OP_DIV_YIDX;
			ST_GET_YIDX: cmd.op = OP_GET_YIDX;
			ST_RD_SP:    cmd.op = OP_RD_SP;
			ST_RD_CP:    cmd.op = OP_RD_CP;
			ST_RD_SY:    cmd.op = OP_RD_SY;
			ST_RD_CY:    cmd.op = OP_RD_CY;
			ST_MUL_H:    cmd.op = OP_MUL_H;
			ST_MUL_V:    cmd.op = OP_MUL_V;
			ST_MUL_X:    cmd.op = OP_MUL_X;
			ST_MUL_Z:    cmd.op = OP_MUL_Z;
			ST_TGT_Z:    cmd.op = OP_TGT_Z;
			ST_DIFF:     cmd.op = OP_DIFF;
			ST_SDIV_X:   cmd.op = OP_SDIV_X;
			ST_SUM_X:    cmd.op = OP_SUM_X;
			ST_SDIV_Y:   cmd.op = OP_SDIV_Y;
			ST_SUM_Y:    cmd.op = OP_SUM_Y;
			ST_SDIV_Z:   cmd.op = OP_SDIV_Z;
			ST_SUM_Z:    cmd.op = OP_SUM_Z;
			default:     cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/ocu_datapath.sv @@
// ----------------------------------------------------------------------------
// ocu_datapath: arithmetic of the orbit camera update unit
// Angle and zoom update, one shared 32x32 multiplier used for the Q1.15
// products and for reciprocal division by constants, the quarter-wave sine
// table, the smoothing step and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ocu_datapath import ocu_pkg::*; #(
	parameter int TableBits = TRIG_TABLE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire center_t            center,
	input  wire logic               button_held,
	input  wire logic signed [15:0] delta_x,
	input  wire logic signed [15:0] delta_y,
	input  wire logic signed [7:0]  wheel_steps,
	output logic signed      [31:0] pos_x,
	output logic signed      [31:0] pos_y,
	output logic signed      [31:0] pos_z,
	output logic signed      [15:0] pitch_out,
	output logic             [16:0] yaw_out,
	output logic             [30:0] distance_out
);

	localparam int Q4 = 1 << (TableBits - 2);
	localparam int AW = TableBits - 1;
	localparam int MW = TableBits + 7;
	localparam int NW = TableBits + 18;

	// floor(m/45) = (m * ceil(2^28/45)) >> 28 for m below 2^21.
	localparam logic [31:0] RECIP_45 = 32'd5965233;
	localparam int          SHIFT_45 = 28;
	// floor(m/5) = (m * ceil(2^34/5)) >> 34 for m below 2^31.
	localparam logic [31:0] RECIP_5  = 32'd3435973837;
	localparam int          SHIFT_5  = 34;

	// A multiple of a full turn that keeps the yaw sum positive.
	localparam logic [23:0] YAW_BIAS = 24'(46 * TURN_UNITS);
	localparam logic [23:0] TURN_24  = 24'(TURN_UNITS);

	localparam logic signed [23:0] PITCH_HI = 24'(PITCH_LIMIT);
	localparam logic signed [23:0] PITCH_LO = -24'(PITCH_LIMIT);
	localparam logic signed [33:0] DIST_LO  = 34'(DIST_MIN);
	localparam logic signed [33:0] DIST_HI  = 34'sd2147483647;
	localparam logic signed [33:0] POS_HI   = 34'sd2147483647;
	localparam logic signed [33:0] POS_LO   = -34'sd2147483648;

	// Sine or cosine in sign-magnitude form.
	typedef struct packed {
		logic        neg;
		logic [14:0] mag;
	} trig_t;

	// Latched input item.
	logic               held_q;
	logic signed [15:0] dx_q;
	logic signed [15:0] dy_q;
	logic signed [7:0]  wh_q;

	// Camera state.
	logic signed [15:0] pitch_q;
	logic        [16:0] yaw_q;
	logic        [30:0] dist_q;
	logic signed [31:0] pos_q [3];

	// Working registers.
	logic        [23:0]          yw_q;
	logic        [TableBits-1:0] pidx_q;
	logic        [TableBits-1:0] yidx_q;
	logic        [14:0]          rom_q;
	logic                        rneg_q;
	trig_t                       sp_q;
	trig_t                       cp_q;
	trig_t                       sy_q;
	trig_t                       cy_q;
	logic        [63:0]          mul_q;
	logic        [31:0]          h_mag_q;
	logic        [31:0]          v_mag_q;
	logic signed [33:0]          tgt_q  [3];
	logic signed [34:0]          diff_q [3];

	// Combinational signals.
	logic signed [23:0]          p_sum;
	logic signed [15:0]          pitch_next;
	logic        [23:0]          dx_term;
	logic        [23:0]          yw_next;
	logic signed [33:0]          d_sum;
	logic        [30:0]          dist_next;
	logic        [6:0]           yaw_quot;
	logic        [16:0]          yaw_wrapped;
	logic        [17:0]          p18;
	logic        [16:0]          pitch_ang;
	logic        [16:0]          ang_sel;
	logic        [NW-1:0]        ang_num;
	logic        [MW-1:0]        ang_m;
	logic        [TableBits-1:0] trig_idx;
	logic        [TableBits-3:0] trig_rem;
	logic        [AW-1:0]        rom_addr;
	trig_t                       trig_now;
	logic        [31:0]          mul_a;
	logic        [31:0]          mul_b;
	logic        [46:0]          rnd_sum;
	logic        [31:0]          rnd_mag;
	logic        [1:0]           axis;
	logic signed [34:0]          dsel;
	logic        [34:0]          dmag;
	logic        [33:0]          m5_sum;
	logic        [31:0]          m5;
	logic        [29:0]          q5;
	logic signed [33:0]          s_sum;
	logic signed [31:0]          s_sat;
	logic signed [33:0]          cx_ext;
	logic signed [33:0]          cy_ext;
	logic signed [33:0]          cz_ext;
	logic        [14:0]          qsin_rom [Q4+1];

	// Quarter-wave sine table, built at elaboration.
	for (genvar k = 0; k <= Q4; k++) begin : g_rom
		assign qsin_rom[k] = ocu_quarter_sine(k, TableBits);
	end

	// Pitch step and clamp.
	always_comb begin
		p_sum = {{8{pitch_q[15]}}, pitch_q} + {dy_q[15], dy_q, 7'd0};
		if (p_sum > PITCH_HI) begin
			pitch_next = 16'(PITCH_HI);
		end else if (p_sum < PITCH_LO) begin
			pitch_next = 16'(PITCH_LO);
		end else begin
			pitch_next = p_sum[15:0];
		end
	end

	// Yaw step, biased positive ahead of the wrap.
	assign dx_term = held_q ? {dx_q[15], dx_q, 7'd0} : 24'd0;
	assign yw_next = {7'd0, yaw_q} - dx_term + YAW_BIAS;

	// Zoom step and clamp.
	always_comb begin
		d_sum = {3'd0, dist_q} - {{9{wh_q[7]}}, wh_q, 17'd0}
			- {{11{wh_q[7]}}, wh_q, 15'd0};
		if (d_sum < DIST_LO) begin
			dist_next = 31'(DIST_LO);
		end else if (d_sum > DIST_HI) begin
			dist_next = 31'(DIST_HI);
		end else begin
			dist_next = d_sum[30:0];
		end
	end

	// Yaw wrap: subtract the whole turns found by the shared multiplier.
	assign yaw_quot    = mul_q[SHIFT_45 +: 7];
	assign yaw_wrapped = 17'(yw_q - 24'(yaw_quot) * TURN_24);

	// Angle to table index: round(a * 2^bits / 92160), with 92160 = 2^11 * 45.
	assign p18       = {{2{pitch_q[15]}}, pitch_q};
	assign pitch_ang = pitch_q[15] ? 17'(p18 + 18'(TURN_UNITS)) : 17'(p18);
	assign ang_sel   = (cmd.op == OP_DIV_PIDX) ? pitch_ang : yaw_q;
	assign ang_num   = ({{(TableBits + 1){1'b0}}, ang_sel} << TableBits)
		+ NW'(TURN_UNITS / 2);
	assign ang_m     = ang_num[NW-1:11];

	// Table address: fold the index onto the quarter wave.
	always_comb begin
		unique case (cmd.op)
			OP_RD_CP: trig_idx = pidx_q + TableBits'(Q4);
			OP_RD_SY: trig_idx = yidx_q;
			OP_RD_CY: trig_idx = yidx_q + TableBits'(Q4);
			default:  trig_idx = pidx_q;
		endcase
		trig_rem = trig_idx[TableBits-3:0];
		if (trig_idx[TableBits-2]) begin
			rom_addr = AW'(Q4) - AW'(trig_rem);
		end else begin
			rom_addr = AW'(trig_rem);
		end
	end

	assign trig_now = '{neg: rneg_q, mag: rom_q};

	// Rounding of a Q1.15 product magnitude, halves away from zero.
	assign rnd_sum = mul_q[46:0] + 47'd16384;
	assign rnd_mag = rnd_sum[46:15];

	// Smoothing axis for the divide and sum steps.
	always_comb begin
		unique case (cmd.op)
			OP_SDIV_Y, OP_SUM_Y: axis = 2'd1;
			OP_SDIV_Z, OP_SUM_Z: axis = 2'd2;
			default:             axis = 2'd0;
		endcase
	end

	// Rounded difference / 20 = floor(floor((|d| + 10) / 4) / 5).
	assign dsel   = diff_q[axis];
	assign dmag   = dsel[34] ? -dsel : dsel;
	assign m5_sum = dmag[33:0] + 34'd10;
	assign m5     = m5_sum[33:2];
	assign q5     = mul_q[63:SHIFT_5];

	// Position step with saturation.
	always_comb begin
		if (dsel[34]) begin
			s_sum = {{2{pos_q[axis][31]}}, pos_q[axis]} - {4'd0, q5};
		end else begin
			s_sum = {{2{pos_q[axis][31]}}, pos_q[axis]} + {4'd0, q5};
		end
		if (s_sum > POS_HI) begin
			s_sat = 32'(POS_HI);
		end else if (s_sum < POS_LO) begin
			s_sat = 32'(POS_LO);
		end else begin
			s_sat = s_sum[31:0];
		end
	end

	assign cx_ext = {{3{center.x[30]}}, center.x};
	assign cy_ext = {{3{center.y[30]}}, center.y};
	assign cz_ext = {{3{center.z[30]}}, center.z};

	// Operand selection of the shared multiplier.
	always_comb begin
		unique case (cmd.op)
			OP_DIV_YAW: begin
				mul_a = 32'(yw_q[23:11]);
				mul_b = RECIP_45;
			end
			OP_DIV_PIDX, OP_DIV_YIDX: begin
				mul_a = 32'(ang_m);
				mul_b = RECIP_45;
			end
			OP_MUL_H: begin
				mul_a = {1'b0, dist_q};
				mul_b = 32'(cp_q.mag);
			end
			OP_MUL_V: begin
				mul_a = {1'b0, dist_q};
				mul_b = 32'(sp_q.mag);
			end
			OP_MUL_X: begin
				mul_a = h_mag_q;
				mul_b = 32'(sy_q.mag);
			end
			OP_MUL_Z: begin
				mul_a = h_mag_q;
				mul_b = 32'(cy_q.mag);
			end
			OP_SDIV_X, OP_SDIV_Y, OP_SDIV_Z: begin
				mul_a = m5;
				mul_b = RECIP_5;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Camera state; reset clears pitch, yaw and position and sets the distance to its minimum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q  <= '0;
			yaw_q    <= '0;
			dist_q   <= 31'(DIST_MIN);
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
		end else begin
			unique case (cmd.op)
				OP_ANGLES: begin
					if (held_q) begin
						pitch_q <= pitch_next;
					end
					dist_q <= dist_next;
				end
				OP_WRAP_YAW: yaw_q <= yaw_wrapped;
				OP_SUM_X, OP_SUM_Y, OP_SUM_Z: pos_q[axis] <= s_sat;
				default: ;
			endcase
		end
	end

	// Working registers of one update.
	always_ff @(posedge clk) begin
		mul_q  <= mul_a * mul_b;
		rom_q  <= qsin_rom[rom_addr];
		rneg_q <= trig_idx[TableBits-1];
		if (cmd.load) begin
			held_q <= button_held;
			dx_q   <= delta_x;
			dy_q   <= delta_y;
			wh_q   <= wheel_steps;
		end
		unique case (cmd.op)
			OP_ANGLES:   yw_q <= yw_next;
			OP_GET_PIDX: pidx_q <= mul_q[SHIFT_45 +: TableBits];
			OP_GET_YIDX: yidx_q <= mul_q[SHIFT_45 +: TableBits];
			OP_RD_CP:    sp_q <= trig_now;
			OP_RD_SY:    cp_q <= trig_now;
			OP_RD_CY:    sy_q <= trig_now;
			OP_MUL_H:    cy_q <= trig_now;
			OP_MUL_V:    h_mag_q <= rnd_mag;
			OP_MUL_X:    v_mag_q <= rnd_mag;
			OP_MUL_Z: begin
				// x target: center minus h * sin(yaw); h carries the sign of cos(pitch).
				if (cp_q.neg ^ sy_q.neg) begin
					tgt_q[0] <= cx_ext + {2'd0, rnd_mag};
				end else begin
					tgt_q[0] <= cx_ext - {2'd0, rnd_mag};
				end
			end
			OP_TGT_Z: begin
				if (cp_q.neg ^ cy_q.neg) begin
					tgt_q[2] <= cz_ext + {2'd0, rnd_mag};
				end else begin
					tgt_q[2] <= cz_ext - {2'd0, rnd_mag};
				end
				if (sp_q.neg) begin
					tgt_q[1] <= cy_ext - {2'd0, v_mag_q};
				end else begin
					tgt_q[1] <= cy_ext + {2'd0, v_mag_q};
				end
			end
			OP_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					diff_q[i] <= {tgt_q[i][33], tgt_q[i]} - {{3{pos_q[i][31]}}, pos_q[i]};
				end
			end
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pos_x        <= pos_q[0];
			pos_y        <= pos_q[1];
			pos_z        <= pos_q[2];
			pitch_out    <= pitch_q;
			yaw_out      <= yaw_q;
			distance_out <= dist_q;
		end
	end

endmodule

`default_nettype wire

@@ hdl/orbit_camera_update_unit.sv @@
// ----------------------------------------------------------------------------
// orbit_camera_update_unit: orbit camera with smoothed position
// Updates pitch, yaw and orbit distance from one frame of pointer input and
// moves the camera position a twentieth of the way toward its orbit target.
// ----------------------------------------------------------------------------
// One frame tick is taken at a time. After a tick is accepted the controller
// walks 24 steps in a fixed order, the last of which loads the output
// register; a new tick is taken only once it is back in idle. The single
// shared 32x32 multiplier serves the yaw wrap, the two table index
// divisions, four Q1.15 products and three divisions by twenty, one per
// cycle. A waiting result does not hold off the next tick; only the final
// load of the output register waits for it to be taken. The orbit center
// registers can be written at any time the block is idle; there is no
// clearing pass after reset.
`default_nettype none

module orbit_camera_update_unit import ocu_pkg::*; #(
	parameter int TRIG_TABLE_BITS = TRIG_TABLE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	// Frame tick input
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [39:0]       s_tdata,  // delta_x[15:0], delta_y[31:16], wheel_steps[39:32]
	input  wire logic              s_tuser,  // button_held
	// Camera result output
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [159:0]      m_tdata   // pos_x[31:0], pos_y[63:32], pos_z[95:64],
	                                         // pitch_out[111:96], yaw_out[128:112],
	                                         // distance_out[159:129]
);

	center_t            center;
	cmd_t               cmd;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] pitch_out;
	logic        [16:0] yaw_out;
	logic        [30:0] distance_out;

	// Configuration registers.
	ocu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.center  (center)
	);

	// Sequencing controller.
	ocu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Arithmetic and camera state.
	ocu_datapath #(
		.TableBits (TRIG_TABLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.center       (center),
		.button_held  (s_tuser),
		.delta_x      (s_tdata[15:0]),
		.delta_y      (s_tdata[31:16]),
		.wheel_steps  (s_tdata[39:32]),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.pitch_out    (pitch_out),
		.yaw_out      (yaw_out),
		.distance_out (distance_out)
	);

	// Pack the result fields, first field lowest.
	assign m_tdata = {distance_out, yaw_out, pitch_out, pos_z, pos_y, pos_x};

endmodule

`default_nettype wire
